>>> rtl/core/lfu_pkg.sv
// ============================================================================
// lfu_pkg
// Shared constants for the LFU key/value store with LRU tie-break.
// ============================================================================
package lfu_pkg;

    // default number of slots
    localparam int ENTRIES_DEF = 16;

    // field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 32;
    localparam int CAP_W = 5;

    // capacity register after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes carried on s_tuser
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // read value returned by a get that misses
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // use count of a freshly inserted entry
    localparam logic [CNT_W-1:0] CNT_FIRST = 32'd1;

endpackage

>>> rtl/core/lfu_cache_replacement_core.sv
// ============================================================================
// lfu_cache_replacement_core
// Fully associative key/value store, least-frequently-used replacement with
// least-recently-used tie-break, built around one slot RAM swept by a sequencer.
// ============================================================================
//
// channel   direction  contents
// s_*       in         tuser: cmd; tdata: lookup_key, write_value
// m_*       out        tuser: found; tdata: read_value
// capacity  in         capacity_in_use_we / capacity_in_use_wdata, 5 bits
//
// A get hit or a put that changes the store goes from accept to result through
// a scan sweep, which finds the key, free slot and victim, and a second
// read-modify-write sweep, which updates ranks and the target slot. A get miss
// or a put at zero capacity skips the second sweep. s_tready rises in the same
// cycle as the result is set.
// Reset clears the valid bits and the sequencer; slot contents need no clearing.
// A result waits in the output register while the next word is accepted; the
// sequencer holds before emitting if the previous result has not been taken.
//
module lfu_cache_replacement_core #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // capacity register
    input  logic                      capacity_in_use_we,
    input  logic [lfu_pkg::CAP_W-1:0] capacity_in_use_wdata,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [63:0]               s_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic                      s_tuser,   // [0] cmd
    // output stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // [31:0] read_value
    output logic                      m_tuser    // [0] found
);

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int EW    = (CW > lfu_pkg::CAP_W) ? CW : lfu_pkg::CAP_W;
    localparam int KW    = lfu_pkg::KEY_W;
    localparam int VW    = lfu_pkg::VAL_W;
    localparam int NW    = lfu_pkg::CNT_W;
    localparam int REC_W = KW + VW + NW + AW;

    typedef enum logic [2:0] {
        IDLE,
        SCAN,
        DECIDE,
        UPDATE,
        EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic [lfu_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [ENTRIES-1:0]        valid_reg, valid_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      cmd_reg, cmd_next;
    logic [KW-1:0]             key_reg, key_next;
    logic [VW-1:0]             val_reg, val_next;
    logic [CW-1:0]             vcount_reg, vcount_next;
    logic                      found_reg, found_next;
    logic [AW-1:0]             hit_idx_reg, hit_idx_next;
    logic [VW-1:0]             hit_val_reg, hit_val_next;
    logic [NW-1:0]             hit_cnt_reg, hit_cnt_next;
    logic [AW-1:0]             hit_rank_reg, hit_rank_next;
    logic                      have_reg, have_next;
    logic [AW-1:0]             vic_idx_reg, vic_idx_next;
    logic [NW-1:0]             vic_cnt_reg, vic_cnt_next;
    logic [AW-1:0]             vic_rank_reg, vic_rank_next;
    logic                      free_have_reg, free_have_next;
    logic [AW-1:0]             free_idx_reg, free_idx_next;
    logic [AW-1:0]             tgt_idx_reg, tgt_idx_next;
    logic [VW-1:0]             tgt_val_reg, tgt_val_next;
    logic [NW-1:0]             tgt_cnt_reg, tgt_cnt_next;
    logic [AW-1:0]             ref_rank_reg, ref_rank_next;
    logic                      all_older_reg, all_older_next;
    logic                      upd_reg, upd_next;
    logic                      res_found_reg, res_found_next;
    logic [VW-1:0]             res_val_reg, res_val_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic                      m_tuser_reg, m_tuser_next;
    logic [VW-1:0]             m_tdata_reg, m_tdata_next;

    // slot RAM ports
    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [REC_W-1:0] ram_wr_data;
    logic [AW-1:0]    ram_rd_addr;
    logic [REC_W-1:0] ram_rd_data;

    // fields of the slot read in the previous cycle
    logic [KW-1:0] rd_key;
    logic [VW-1:0] rd_val;
    logic [NW-1:0] rd_cnt;
    logic [AW-1:0] rd_rank;
    logic [AW-1:0] slot_idx;
    logic [EW-1:0] eff_cap;
    logic [EW-1:0] cap_ext;

    assign rd_key   = ram_rd_data[0 +: KW];
    assign rd_val   = ram_rd_data[KW +: VW];
    assign rd_cnt   = ram_rd_data[KW + VW +: NW];
    assign rd_rank  = ram_rd_data[KW + VW + NW +: AW];
    assign slot_idx = AW'(cnt_reg - CW'(1));

    // capacity clipped to the slot count
    assign cap_ext = EW'(cap_reg);
    assign eff_cap = (cap_ext > EW'(ENTRIES)) ? EW'(ENTRIES) : cap_ext;

    lfu_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // sequencer next-state logic
    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        vcount_next    = vcount_reg;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_val_next   = hit_val_reg;
        hit_cnt_next   = hit_cnt_reg;
        hit_rank_next  = hit_rank_reg;
        have_next      = have_reg;
        vic_idx_next   = vic_idx_reg;
        vic_cnt_next   = vic_cnt_reg;
        vic_rank_next  = vic_rank_reg;
        free_have_next = free_have_reg;
        free_idx_next  = free_idx_reg;
        tgt_idx_next   = tgt_idx_reg;
        tgt_val_next   = tgt_val_reg;
        tgt_cnt_next   = tgt_cnt_reg;
        ref_rank_next  = ref_rank_reg;
        all_older_next = all_older_reg;
        upd_next       = upd_reg;
        res_found_next = res_found_reg;
        res_val_next   = res_val_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tuser_next   = m_tuser_reg;
        m_tdata_next   = m_tdata_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = slot_idx;
        ram_wr_data = ram_rd_data;
        ram_rd_addr = cnt_reg[AW-1:0];

        // capacity write
        if (capacity_in_use_we)
        begin
            cap_next = capacity_in_use_wdata;
        end

        // result taken downstream
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next       = s_tuser;
                    key_next       = s_tdata[31:0];
                    val_next       = s_tdata[63:32];
                    cnt_next       = '0;
                    vcount_next    = '0;
                    found_next     = 1'b0;
                    have_next      = 1'b0;
                    free_have_next = 1'b0;
                    state_next     = SCAN;
                end
            end

            // sweep 1: key match, valid count, first free slot, lfu/lru victim
            SCAN:
            begin
                if (cnt_reg != '0)
                begin
                    if (valid_reg[slot_idx])
                    begin
                        vcount_next = vcount_reg + CW'(1);
                        if (!found_reg && rd_key == key_reg)
                        begin
                            found_next    = 1'b1;
                            hit_idx_next  = slot_idx;
                            hit_val_next  = rd_val;
                            hit_cnt_next  = rd_cnt;
                            hit_rank_next = rd_rank;
                        end
                        if (!have_reg || rd_cnt < vic_cnt_reg ||
                            (rd_cnt == vic_cnt_reg && rd_rank > vic_rank_reg))
                        begin
                            have_next     = 1'b1;
                            vic_idx_next  = slot_idx;
                            vic_cnt_next  = rd_cnt;
                            vic_rank_next = rd_rank;
                        end
                    end
                    else if (!free_have_reg)
                    begin
                        free_have_next = 1'b1;
                        free_idx_next  = slot_idx;
                    end
                end
                if (cnt_reg == CW'(ENTRIES))
                begin
                    state_next = DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            // choose the target slot and its new contents
            DECIDE:
            begin
                cnt_next       = '0;
                res_found_next = found_reg;
                res_val_next   = '0;
                upd_next       = 1'b0;
                tgt_idx_next   = hit_idx_reg;
                tgt_val_next   = (cmd_reg == lfu_pkg::CMD_GET) ? hit_val_reg : val_reg;
                tgt_cnt_next   = (hit_cnt_reg == '1) ? hit_cnt_reg : hit_cnt_reg + NW'(1);
                ref_rank_next  = hit_rank_reg;
                all_older_next = 1'b0;
                if (cmd_reg == lfu_pkg::CMD_GET)
                begin
                    res_val_next = found_reg ? hit_val_reg : lfu_pkg::MISS_VALUE;
                    upd_next     = found_reg;
                end
                else if (eff_cap != '0)
                begin
                    upd_next = 1'b1;
                    if (!found_reg)
                    begin
                        tgt_cnt_next = lfu_pkg::CNT_FIRST;
                        if (EW'(vcount_reg) < eff_cap)
                        begin
                            tgt_idx_next   = free_idx_reg;
                            all_older_next = 1'b1;
                        end
                        else
                        begin
                            tgt_idx_next  = vic_idx_reg;
                            ref_rank_next = vic_rank_reg;
                        end
                    end
                end
                state_next = (cmd_reg == lfu_pkg::CMD_GET && !found_reg) ||
                             (cmd_reg == lfu_pkg::CMD_PUT && eff_cap == '0) ? EMIT : UPDATE;
            end

            // sweep 2: age ranks and rewrite the target slot
            UPDATE:
            begin
                if (cnt_reg != '0)
                begin
                    if (slot_idx == tgt_idx_reg)
                    begin
                        ram_wr_en             = 1'b1;
                        ram_wr_data           = {AW'(0), tgt_cnt_reg, tgt_val_reg, key_reg};
                        valid_next[slot_idx]  = 1'b1;
                    end
                    else if (valid_reg[slot_idx] &&
                             (all_older_reg || rd_rank < ref_rank_reg))
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = {rd_rank + AW'(1), rd_cnt, rd_val, rd_key};
                    end
                end
                if (cnt_reg == CW'(ENTRIES))
                begin
                    state_next = EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            // hand the result to the output register once it is free
            EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_found_reg;
                    m_tdata_next  = res_val_reg;
                    state_next    = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cap_reg       <= lfu_pkg::CAP_RESET;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            cmd_reg       <= lfu_pkg::CMD_GET;
            key_reg       <= '0;
            val_reg       <= '0;
            vcount_reg    <= '0;
            found_reg     <= 1'b0;
            hit_idx_reg   <= '0;
            hit_val_reg   <= '0;
            hit_cnt_reg   <= '0;
            hit_rank_reg  <= '0;
            have_reg      <= 1'b0;
            vic_idx_reg   <= '0;
            vic_cnt_reg   <= '0;
            vic_rank_reg  <= '0;
            free_have_reg <= 1'b0;
            free_idx_reg  <= '0;
            tgt_idx_reg   <= '0;
            tgt_val_reg   <= '0;
            tgt_cnt_reg   <= '0;
            ref_rank_reg  <= '0;
            all_older_reg <= 1'b0;
            upd_reg       <= 1'b0;
            res_found_reg <= 1'b0;
            res_val_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tuser_reg   <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            cmd_reg       <= cmd_next;
            key_reg       <= key_next;
            val_reg       <= val_next;
            vcount_reg    <= vcount_next;
            found_reg     <= found_next;
            hit_idx_reg   <= hit_idx_next;
            hit_val_reg   <= hit_val_next;
            hit_cnt_reg   <= hit_cnt_next;
            hit_rank_reg  <= hit_rank_next;
            have_reg      <= have_next;
            vic_idx_reg   <= vic_idx_next;
            vic_cnt_reg   <= vic_cnt_next;
            vic_rank_reg  <= vic_rank_next;
            free_have_reg <= free_have_next;
            free_idx_reg  <= free_idx_next;
            tgt_idx_reg   <= tgt_idx_next;
            tgt_val_reg   <= tgt_val_next;
            tgt_cnt_reg   <= tgt_cnt_next;
            ref_rank_reg  <= ref_rank_next;
            all_older_reg <= all_older_next;
            upd_reg       <= upd_next;
            res_found_reg <= res_found_next;
            res_val_reg   <= res_val_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tuser_reg   <= m_tuser_next;
            m_tdata_reg   <= m_tdata_next;
        end
    end

    // port drive
    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // slot RAM is only written during the update sweep, and only when one is due
    a_wr_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == UPDATE && upd_reg))
        else $error("slot write outside update sweep");

    // valid entries are never dropped
    a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(valid_reg) >= $countones($past(valid_reg)))
        else $error("valid entry lost");

    // scan count agrees with the valid bits
    a_vcount: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DECIDE |-> 32'(vcount_reg) == $countones(valid_reg))
        else $error("valid count mismatch");

    // a hit always points at a valid slot
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DECIDE && found_reg) |-> valid_reg[hit_idx_reg])
        else $error("hit on invalid slot");

    // an insert below capacity always has a free slot to take
    a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DECIDE && cmd_reg == lfu_pkg::CMD_PUT && !found_reg &&
         EW'(vcount_reg) < eff_cap) |-> free_have_reg)
        else $error("no free slot for insert");
`endif

endmodule

>>> rtl/core/lfu_ram.sv
// ============================================================================
// lfu_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module lfu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> tb/lfu_result_checker.sv
// ============================================================================
// lfu_result_checker
// Watches the capacity port and both streams of the LFU store. For every
// accepted input word it predicts the result from its own copy of the slots,
// then compares each accepted output word with the oldest prediction.
// ============================================================================
module lfu_result_checker #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      capacity_in_use_we,
    input  logic [lfu_pkg::CAP_W-1:0] capacity_in_use_wdata,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [63:0]               s_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic                      s_tuser,   // [0] cmd
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [31:0]               m_tdata,   // [31:0] read_value
    input  logic                      m_tuser,   // [0] found
    output int                        mismatch_count,
    output int                        outstanding
);

    typedef struct packed {
        logic                      found;
        logic [lfu_pkg::VAL_W-1:0] read_value;
    } lfu_result_t;

    // predicted copy of the store
    logic [lfu_pkg::CAP_W-1:0] capacity;
    logic                      slot_valid [ENTRIES];
    logic [lfu_pkg::KEY_W-1:0] slot_key   [ENTRIES];
    logic [lfu_pkg::VAL_W-1:0] slot_val   [ENTRIES];
    logic [lfu_pkg::CNT_W-1:0] slot_uses  [ENTRIES];
    logic [8:0]                slot_rank  [ENTRIES];

    lfu_result_t pending_results [$];
    lfu_result_t oldest_result;
    lfu_result_t fresh_result;

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t lfu_result_checker: %s: expected %h, got %h", $time, what, want, got);
        mismatch_count = mismatch_count + 1;
    endtask

    // move slot s to rank 0; all_older ages every other valid entry, else only the more recent ones
    task automatic make_recent(input int s, input bit all_older);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (i != s && slot_valid[i] && (all_older || slot_rank[i] < slot_rank[s]))
                slot_rank[i] = slot_rank[i] + 1;
        end
        slot_rank[s] = '0;
    endtask

    // one more use, saturating, and most recent
    task automatic touch_entry(input int s);
        if (slot_uses[s] != '1)
            slot_uses[s] = slot_uses[s] + 1;
        make_recent(s, 1'b0);
    endtask

    // apply one get or put to the copy and return its result
    task automatic predict_op(input logic op, input logic [lfu_pkg::KEY_W-1:0] key,
                              input logic [lfu_pkg::VAL_W-1:0] val,
                              output lfu_result_t res);
        int          hit;
        int          used;
        int          target;
        int unsigned eff;
        bit          present;
        bit          have;
        hit     = 0;
        used    = 0;
        target  = 0;
        present = 1'b0;
        have    = 1'b0;
        eff     = (capacity > ENTRIES) ? ENTRIES : capacity;

        // first matching valid slot, and how many are valid
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (slot_valid[i])
            begin
                used++;
                if (!present && slot_key[i] == key)
                begin
                    present = 1'b1;
                    hit     = i;
                end
            end
        end

        res.found      = present;
        res.read_value = '0;

        if (op == lfu_pkg::CMD_GET)
        begin
            if (present)
            begin
                res.read_value = slot_val[hit];
                touch_entry(hit);
            end
            else
            begin
                res.read_value = lfu_pkg::MISS_VALUE;
            end
        end
        else if (eff != 0)
        begin
            if (present)
            begin
                slot_val[hit] = val;
                touch_entry(hit);
            end
            else
            begin
                if (used < eff)
                begin
                    // lowest free slot
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (!slot_valid[i])
                            target = i;
                    make_recent(target, 1'b1);
                end
                else
                begin
                    // fewest uses, oldest among equals
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (slot_valid[i] && (!have || slot_uses[i] < slot_uses[target] ||
                            (slot_uses[i] == slot_uses[target] &&
                             slot_rank[i] > slot_rank[target])))
                        begin
                            target = i;
                            have   = 1'b1;
                        end
                    end
                    make_recent(target, 1'b0);
                end
                slot_valid[target] = 1'b1;
                slot_key[target]   = key;
                slot_val[target]   = val;
                slot_uses[target]  = lfu_pkg::CNT_FIRST;
            end
        end
    endtask

    // sample both channels and the capacity port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity = lfu_pkg::CAP_RESET;
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_val[i]   = '0;
                slot_uses[i]  = '0;
                slot_rank[i]  = '0;
            end
            pending_results.delete();
            mismatch_count = 0;
            outstanding   <= 0;
        end
        else
        begin
            if (capacity_in_use_we)
                capacity = capacity_in_use_wdata;

            // result word against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result word with nothing pending", '0, m_tdata);
                else
                begin
                    oldest_result = pending_results.pop_front();
                    if (m_tuser !== oldest_result.found)
                        report_mismatch("found", {31'd0, oldest_result.found},
                                        {31'd0, m_tuser});
                    if (m_tdata !== oldest_result.read_value)
                        report_mismatch("read_value", oldest_result.read_value, m_tdata);
                end
            end

            // input word into the predictor
            if (s_tvalid && s_tready)
            begin
                predict_op(s_tuser, s_tdata[31:0], s_tdata[63:32], fresh_result);
                pending_results.push_back(fresh_result);
            end

            outstanding <= pending_results.size();
        end
    end

endmodule

>>> tb/tb_lfu_cache_replacement_core.sv
// ============================================================================
// tb_lfu_cache_replacement_core
// Drives gets and puts into the LFU store under bursty input and a stalling
// receiver, across several capacity settings. A directed opening covers the
// key and value extremes, update, miss, eviction with the recency tie-break,
// a capacity lowered below the entry count, zero and oversized capacity;
// random phases then work a small key pool per setting so hits and
// evictions are frequent. Checking is done by lfu_result_checker.
// ============================================================================
module tb_lfu_cache_replacement_core;

    localparam int ENTRIES     = 16;
    localparam int PHASE_WORDS = 45;
    localparam int NUM_PHASES  = 10;

    logic                      clk                   = 1'b0;
    logic                      rst_n                 = 1'b0;
    logic                      capacity_in_use_we    = 1'b0;
    logic [lfu_pkg::CAP_W-1:0] capacity_in_use_wdata = '0;
    logic                      s_tvalid              = 1'b0;
    logic                      s_tready;
    logic [63:0]               s_tdata               = '0;   // [31:0] lookup_key, [63:32] write_value
    logic                      s_tuser               = 1'b0; // [0] cmd
    logic                      m_tvalid;
    logic                      m_tready              = 1'b0;
    logic [31:0]               m_tdata;                      // [31:0] read_value
    logic                      m_tuser;                      // [0] found

    int                        mismatch_count;
    int                        outstanding;

    bit                        in_burst              = 1'b0;
    int                        burst_left            = 0;
    int                        ready_left            = 0;

    logic [lfu_pkg::KEY_W-1:0] key_pool [32];
    int                        pool_size;
    int                        phase_caps [NUM_PHASES] = '{31, 16, 1, 4, 0, 8, 17, 3, 16, 2};

    lfu_cache_replacement_core #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .capacity_in_use_we    (capacity_in_use_we),
        .capacity_in_use_wdata (capacity_in_use_wdata),
        .s_tvalid              (s_tvalid),
        .s_tready              (s_tready),
        .s_tdata               (s_tdata),
        .s_tuser               (s_tuser),
        .m_tvalid              (m_tvalid),
        .m_tready              (m_tready),
        .m_tdata               (m_tdata),
        .m_tuser               (m_tuser)
    );

    lfu_result_checker #(
        .ENTRIES(ENTRIES)
    ) checker_inst (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .capacity_in_use_we    (capacity_in_use_we),
        .capacity_in_use_wdata (capacity_in_use_wdata),
        .s_tvalid              (s_tvalid),
        .s_tready              (s_tready),
        .s_tdata               (s_tdata),
        .s_tuser               (s_tuser),
        .m_tvalid              (m_tvalid),
        .m_tready              (m_tready),
        .m_tdata               (m_tdata),
        .m_tuser               (m_tuser),
        .mismatch_count        (mismatch_count),
        .outstanding           (outstanding)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: alternating ready and stall runs, some long
    always @(posedge clk)
    begin
        if (ready_left != 0)
            ready_left <= ready_left - 1;
        else if (m_tready)
        begin
            m_tready   <= 1'b0;
            ready_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 4);
        end
        else
        begin
            m_tready   <= 1'b1;
            ready_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(0, 20);
        end
    end

    // one input word; bursts of words with gaps between them
    task automatic send_word(input logic op, input logic [lfu_pkg::KEY_W-1:0] key,
                             input logic [lfu_pkg::VAL_W-1:0] val);
        int gap;
        if (!in_burst)
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
            in_burst   = 1'b1;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, key};
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            in_burst  = 1'b0;
        end
    endtask

    // drop valid if a burst is still open
    task automatic end_burst();
        if (in_burst)
        begin
            s_tvalid <= 1'b0;
            in_burst  = 1'b0;
        end
    endtask

    // every predicted result has been taken
    task automatic wait_idle();
        do @(posedge clk); while (outstanding != 0);
    endtask

    // capacity write, only with the store idle
    task automatic write_capacity(input int cap);
        end_burst();
        wait_idle();
        capacity_in_use_we    <= 1'b1;
        capacity_in_use_wdata <= cap[lfu_pkg::CAP_W-1:0];
        @(posedge clk);
        capacity_in_use_we    <= 1'b0;
    endtask

    // stimulus and verdict
    initial
    begin
        int                        eff;
        logic [lfu_pkg::KEY_W-1:0] key;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, update, miss, at reset capacity
        send_word(lfu_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(lfu_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(lfu_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(lfu_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        send_word(lfu_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(lfu_pkg::CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(lfu_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(lfu_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(lfu_pkg::CMD_PUT, 32'h0000_0000, 32'h1234_5678);
        send_word(lfu_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(lfu_pkg::CMD_GET, 32'h0000_0001, 32'h0000_0000);

        // capacity below the entry count: new keys evict, oldest of the least used
        write_capacity(2);
        send_word(lfu_pkg::CMD_PUT, 32'h0000_0055, 32'h0000_0001);
        send_word(lfu_pkg::CMD_PUT, 32'h0000_00AA, 32'h0000_0002);
        send_word(lfu_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_word(lfu_pkg::CMD_GET, 32'h0000_00AA, 32'h0000_0000);

        // zero capacity: puts ignored, gets still hit
        write_capacity(0);
        send_word(lfu_pkg::CMD_PUT, 32'h0000_0033, 32'h0000_0003);
        send_word(lfu_pkg::CMD_PUT, 32'h0000_00AA, 32'h0000_0004);
        send_word(lfu_pkg::CMD_GET, 32'h0000_00AA, 32'h0000_0000);
        send_word(lfu_pkg::CMD_GET, 32'h0000_0033, 32'h0000_0000);

        // capacity above the slot count
        write_capacity(31);
        send_word(lfu_pkg::CMD_PUT, 32'h0000_0033, 32'h0000_0005);
        send_word(lfu_pkg::CMD_PUT, 32'hDEAD_BEEF, 32'hCAFE_F00D);
        send_word(lfu_pkg::CMD_GET, 32'h0000_0033, 32'h0000_0000);
        send_word(lfu_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);

        // random phases over a small key pool per capacity
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(phase_caps[p]);
            eff       = (phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p];
            pool_size = eff + $urandom_range(1, 6);
            for (int k = 0; k < pool_size; k++)
                key_pool[k] = $urandom;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                key = ($urandom_range(0, 6) == 0) ? $urandom
                                                  : key_pool[$urandom_range(0, pool_size - 1)];
                send_word(logic'($urandom_range(0, 1)), key, $urandom);
            end
        end

        // drain and settle
        end_burst();
        wait_idle();
        repeat (80) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_lfu_cache_replacement_core: done, clean");
        else
            $display("tb_lfu_cache_replacement_core: done, errors");
        $finish;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("tb_lfu_cache_replacement_core: done, errors");
        $finish;
    end

endmodule
